### hdl/color_lut_3d_diagonal_interp_core_assert.svh
// Assertion macros shared by the checker of the color LUT core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef COLOR_LUT_3D_DIAGONAL_INTERP_CORE_ASSERT_SVH
`define COLOR_LUT_3D_DIAGONAL_INTERP_CORE_ASSERT_SVH

// Antecedent implies consequent, checked at every rising edge out of reset.
`define CLUT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clut3d: implication check failed");

// Expression must never be true out of reset.
`define CLUT_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("clut3d: forbidden condition seen");

`endif

### hdl/clut3d_pkg.sv
// Shared types and constants of the 3D color LUT core.
// No dependencies; every other file of the core but the assertion header uses it.
`default_nettype none

package clut3d_pkg;

    localparam int GRID_POINTS     = 32;
    localparam int ENTRY_FRAC_BITS = 12;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CELL        = 256 / GRID_POINTS;
    localparam int CELL_BITS   = $clog2(CELL);
    localparam int COORD_BITS  = $clog2(GRID_POINTS);
    localparam int ADDR_BITS   = 3 * COORD_BITS;
    localparam int TABLE_SIZE  = GRID_POINTS * GRID_POINTS * GRID_POINTS;
    localparam int ENTRY_BITS  = 13;
    localparam int INDEX_BITS  = 15;
    localparam int PIXEL_BITS  = 8;
    localparam int NUM_BITS    = ENTRY_BITS + CELL_BITS;
    localparam int PROD_BITS   = NUM_BITS + 8;
    localparam int SCALE_SHIFT = CELL_BITS + ENTRY_FRAC_BITS;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_GRADE = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        JOB_WRITE = 1'b0,
        JOB_GRADE = 1'b1
    } job_kind_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [PIXEL_BITS-1:0]   pixel_red;
        logic [PIXEL_BITS-1:0]   pixel_green;
        logic [PIXEL_BITS-1:0]   pixel_blue;
        logic [INDEX_BITS-1:0]   entry_index;
        logic [ENTRY_BITS-1:0]   entry_red;
        logic [ENTRY_BITS-1:0]   entry_green;
        logic [ENTRY_BITS-1:0]   entry_blue;
    } clut_in_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] graded_red;
        logic [PIXEL_BITS-1:0] graded_green;
        logic [PIXEL_BITS-1:0] graded_blue;
    } clut_out_t;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] red;
        logic [ENTRY_BITS-1:0] green;
        logic [ENTRY_BITS-1:0] blue;
    } entry_t;

    typedef struct packed {
        logic [CELL_BITS-1:0] red;
        logic [CELL_BITS-1:0] green;
        logic [CELL_BITS-1:0] blue;
    } frac_t;

    typedef struct packed {
        job_kind_t            kind;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
        entry_t               data;
        frac_t                frac;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### hdl/clut3d_front.sv
// Front end of the 3D color LUT core: accepts words, tracks table
// readiness, and turns words into write or grade jobs. Uses clut3d_pkg.
`default_nettype none

module clut3d_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire clut3d_pkg::clut_in_t        item,
    input  wire clut3d_pkg::queue_status_t   status,
    output logic                             push,
    output clut3d_pkg::job_t                 job
);

    logic table_ready_reg;
    logic table_ready_next;
    logic accept;
    logic index_ok;
    logic index_last;
    logic [clut3d_pkg::COORD_BITS-1:0] coord_r;
    logic [clut3d_pkg::COORD_BITS-1:0] coord_g;
    logic [clut3d_pkg::COORD_BITS-1:0] coord_b;

    // Clamp the top grid cell down one so the diagonal neighbor stays inside.
    function automatic logic [clut3d_pkg::COORD_BITS-1:0] grid_coord(
        input logic [clut3d_pkg::PIXEL_BITS-1:0] c
    );
        logic [clut3d_pkg::COORD_BITS-1:0] g;
        g = clut3d_pkg::COORD_BITS'(c >> clut3d_pkg::CELL_BITS);
        if (g == clut3d_pkg::COORD_BITS'(clut3d_pkg::GRID_POINTS - 1))
            g = clut3d_pkg::COORD_BITS'(clut3d_pkg::GRID_POINTS - 2);
        return g;
    endfunction

    assign accept     = start && !status.full;
    assign index_ok   = int'(item.entry_index) < clut3d_pkg::TABLE_SIZE;
    assign index_last = int'(item.entry_index) == clut3d_pkg::TABLE_SIZE - 1;

    assign coord_r = grid_coord(item.pixel_red);
    assign coord_g = grid_coord(item.pixel_green);
    assign coord_b = grid_coord(item.pixel_blue);

    always_comb
    begin
        job.addr_a     = {coord_b, coord_g, coord_r};
        job.addr_b     = {coord_b + 1'b1, coord_g + 1'b1, coord_r + 1'b1};
        job.data.red   = item.entry_red;
        job.data.green = item.entry_green;
        job.data.blue  = item.entry_blue;
        job.frac.red   = item.pixel_red[clut3d_pkg::CELL_BITS-1:0];
        job.frac.green = item.pixel_green[clut3d_pkg::CELL_BITS-1:0];
        job.frac.blue  = item.pixel_blue[clut3d_pkg::CELL_BITS-1:0];
        job.kind       = clut3d_pkg::JOB_WRITE;
        push             = 1'b0;
        table_ready_next = table_ready_reg;
        unique case (item.opcode)
            clut3d_pkg::OP_LOAD:
            begin
                // Write jobs address the table through addr_a.
                job.addr_a = clut3d_pkg::ADDR_BITS'(item.entry_index);
                push       = accept && index_ok;
                if (accept && index_last)
                    table_ready_next = 1'b1;
            end
            clut3d_pkg::OP_GRADE:
            begin
                job.kind = clut3d_pkg::JOB_GRADE;
                // Drop pixels until the last table entry has been loaded.
                push     = accept && table_ready_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_ready_reg <= 1'b0;
        else
            table_ready_reg <= table_ready_next;
    end

endmodule

`default_nettype wire

### hdl/clut3d_queue.sv
// Short job queue between the front and back of the 3D color LUT core.
// Uses clut3d_pkg for the job and status types.
`default_nettype none

module clut3d_queue #(
    parameter int DEPTH = clut3d_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire clut3d_pkg::job_t            job_in,
    input  wire logic                        pop,
    output clut3d_pkg::job_t                 job_out,
    output clut3d_pkg::queue_status_t        status
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    clut3d_pkg::job_t slot_reg [DEPTH];

    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign status.full  = count_reg == COUNT_BITS'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign job_out      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/clut3d_back.sv
// Back end of the 3D color LUT core: table memory, diagonal interpolation
// and output scaling in a three-stage pipeline. Uses clut3d_pkg.
`default_nettype none

module clut3d_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    input  wire clut3d_pkg::job_t     job,
    output clut3d_pkg::clut_out_t     result,
    output logic                      result_valid
);

    clut3d_pkg::entry_t table_mem [clut3d_pkg::TABLE_SIZE];

    clut3d_pkg::entry_t rd_a_reg;
    clut3d_pkg::entry_t rd_b_reg;
    clut3d_pkg::frac_t  frac_reg;
    logic [clut3d_pkg::NUM_BITS-1:0] num_r_reg, num_g_reg, num_b_reg;
    clut3d_pkg::clut_out_t result_reg;
    logic valid0_reg, valid1_reg, valid2_reg;

    // s*(CELL-f) + e*f
    function automatic logic [clut3d_pkg::NUM_BITS-1:0] blend(
        input logic [clut3d_pkg::ENTRY_BITS-1:0] s,
        input logic [clut3d_pkg::ENTRY_BITS-1:0] e,
        input logic [clut3d_pkg::CELL_BITS-1:0]  f
    );
        logic [clut3d_pkg::CELL_BITS:0] w_s;
        logic [clut3d_pkg::CELL_BITS:0] w_e;
        w_s = (clut3d_pkg::CELL_BITS + 1)'(clut3d_pkg::CELL) - {1'b0, f};
        w_e = {1'b0, f};
        return clut3d_pkg::NUM_BITS'(s) * clut3d_pkg::NUM_BITS'(w_s)
             + clut3d_pkg::NUM_BITS'(e) * clut3d_pkg::NUM_BITS'(w_e);
    endfunction

    // num*255 / (CELL * 2^frac), truncated, clipped to 255
    function automatic logic [clut3d_pkg::PIXEL_BITS-1:0] scale_sat(
        input logic [clut3d_pkg::NUM_BITS-1:0] num
    );
        logic [clut3d_pkg::PROD_BITS-1:0] prod;
        logic [clut3d_pkg::PROD_BITS-1:0] q;
        prod = {num, 8'h00} - clut3d_pkg::PROD_BITS'(num);
        q    = prod >> clut3d_pkg::SCALE_SHIFT;
        if (q > clut3d_pkg::PROD_BITS'(255))
            return 8'hFF;
        return q[clut3d_pkg::PIXEL_BITS-1:0];
    endfunction

    // Stage 0: write a loaded entry, or read the base and diagonal entries.
    always_ff @(posedge clk)
    begin
        if (job_valid && job.kind == clut3d_pkg::JOB_WRITE)
            table_mem[job.addr_a] <= job.data;
        rd_a_reg <= table_mem[job.addr_a];
        rd_b_reg <= table_mem[job.addr_b];
        frac_reg <= job.frac;
    end

    // Stage 1: weight the two entries per channel.
    always_ff @(posedge clk)
    begin
        num_r_reg <= blend(rd_a_reg.red,   rd_b_reg.red,   frac_reg.red);
        num_g_reg <= blend(rd_a_reg.green, rd_b_reg.green, frac_reg.green);
        num_b_reg <= blend(rd_a_reg.blue,  rd_b_reg.blue,  frac_reg.blue);
    end

    // Stage 2: scale to 8 bits.
    always_ff @(posedge clk)
    begin
        result_reg.graded_red   <= scale_sat(num_r_reg);
        result_reg.graded_green <= scale_sat(num_g_reg);
        result_reg.graded_blue  <= scale_sat(num_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= job_valid && job.kind == clut3d_pkg::JOB_GRADE;
            valid1_reg <= valid0_reg;
            valid2_reg <= valid1_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid2_reg;

endmodule

`default_nettype wire

### hdl/color_lut_3d_diagonal_interp_core.sv
// Timing: a graded word is on result for one cycle; its pixel word passes the
//   queue register, then the read, blend and scale registers, in that order.
// Throughput: one word per clock, set by the table memory serving one
//   write or one pair of reads per word in the back pipeline.
// Reset (rst_n, async, low): clears the ready flag, queue and pipeline
//   valids; table contents stay undefined until loaded, no clearing pass.
`default_nettype none

module color_lut_3d_diagonal_interp_core #(
    parameter int QUEUE_DEPTH = clut3d_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire clut3d_pkg::clut_in_t    item,
    output logic                         busy,
    output clut3d_pkg::clut_out_t        result,
    output logic                         result_valid
);

    // Front end classifies each word into a table write or a grade job.
    // Load words past the table end and pixel words that arrive before the
    // last table entry has been loaded produce no job at all.
    clut3d_pkg::queue_status_t status;
    clut3d_pkg::job_t          front_job;
    clut3d_pkg::job_t          head_job;
    logic                      push;

    // The back end drains one job every cycle it finds one, since results
    // cannot be held off; busy only rises if the queue ever fills.
    assign busy = status.full;

    clut3d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .status (status),
        .push   (push),
        .job    (front_job)
    );

    // Jobs pass in order, so a pixel queued behind a load sees that entry.
    clut3d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (front_job),
        .pop     (!status.empty),
        .job_out (head_job),
        .status  (status)
    );

    // Back end: memory access, blend, then scale and clip to 0..255.
    clut3d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!status.empty),
        .job          (head_job),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

### hdl/clut3d_checker.sv
// Port-level checker for the 3D color LUT core, bound to the top level.
// Uses clut3d_pkg and the assertion macro header.
`default_nettype none

`include "color_lut_3d_diagonal_interp_core_assert.svh"

module clut3d_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire clut3d_pkg::clut_in_t    item,
    input wire logic                    busy,
    input wire clut3d_pkg::clut_out_t   result,
    input wire logic                    result_valid
);

    logic pixel_taken;
    logic load_taken;

    assign pixel_taken = start && !busy && item.opcode == clut3d_pkg::OP_GRADE;
    assign load_taken  = start && !busy && item.opcode == clut3d_pkg::OP_LOAD;

    // The back end drains a job each cycle, so the queue never fills.
    `CLUT_ASSERT_NEVER(a_never_busy, busy)
    // Every result traces back to a pixel word taken earlier.
    `CLUT_ASSERT_IMPLY(a_result_from_pixel, result_valid, $past(pixel_taken, 4))
    // A load word leaves its result slot empty.
    `CLUT_ASSERT_IMPLY(a_load_gives_none, load_taken, ##4 !result_valid)

endmodule

bind color_lut_3d_diagonal_interp_core clut3d_checker u_checker (.*);

`default_nettype wire

### sim/tb.sv
// Self-checking bench for color_lut_3d_diagonal_interp_core: loads the grading table,
// grades pixels and checks every graded word against a local grading model.
// Depends on clut3d_pkg and the core RTL only.
`default_nettype none

module tb;

    localparam int GRID_POINTS     = clut3d_pkg::GRID_POINTS;
    localparam int CELL            = clut3d_pkg::CELL;
    localparam int TABLE_SIZE      = clut3d_pkg::TABLE_SIZE;
    localparam int PIXEL_BITS      = clut3d_pkg::PIXEL_BITS;
    localparam int INDEX_BITS      = clut3d_pkg::INDEX_BITS;
    localparam int ENTRY_BITS      = clut3d_pkg::ENTRY_BITS;
    localparam int ENTRY_FRAC_BITS = clut3d_pkg::ENTRY_FRAC_BITS;

    // Step from a grid point to its neighbor one cell further on all three axes,
    // the base of the top grid cell, and the last table index (sets ready).
    localparam int DIAG_STEP = 1 + GRID_POINTS + GRID_POINTS * GRID_POINTS;
    localparam int TOP_BASE  = (GRID_POINTS - 2) * DIAG_STEP;
    localparam int LAST_IDX  = TABLE_SIZE - 1;
    localparam int RAND_WORDS = 1680;

    typedef struct {
        clut3d_pkg::clut_in_t  w;
        bit                    typed;    // expectation written into the row
        bit                    n_want;   // typed row: one graded word or none
        clut3d_pkg::clut_out_t want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    clut3d_pkg::clut_in_t  item = '0;
    logic                  busy;
    clut3d_pkg::clut_out_t result;
    logic                  result_valid;

    // Local copy of the grading table, which entries hold data, and the ready flag.
    clut3d_pkg::entry_t    lut_model [TABLE_SIZE];
    bit                    lut_loaded [TABLE_SIZE];
    bit                    lut_ready;

    clut3d_pkg::clut_out_t graded_q [$];
    plan_row_t             plan [$];

    int        err_count;
    int        n_loads;
    int        n_pixels;
    int        n_checked;
    int        burst_left;

    color_lut_3d_diagonal_interp_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Grid coordinate of one channel; the top cell absorbs the last code range.
    function automatic int unsigned grid_axis(input logic [PIXEL_BITS-1:0] c);
        int unsigned g;
        g = c / CELL;
        if (g >= GRID_POINTS - 1)
            g = GRID_POINTS - 2;
        return g;
    endfunction

    function automatic void lut_addr(input clut3d_pkg::clut_in_t w,
                                     output int unsigned base,
                                     output int unsigned diag);
        base = grid_axis(w.pixel_red)
             + GRID_POINTS * (grid_axis(w.pixel_green)
             + GRID_POINTS * grid_axis(w.pixel_blue));
        diag = base + DIAG_STEP;
    endfunction

    // Blend start and diagonal entry by f/CELL, scale to 0..255, truncate, saturate.
    function automatic logic [PIXEL_BITS-1:0] scale_channel(input int unsigned s,
                                                            input int unsigned e,
                                                            input int unsigned f);
        longint unsigned num;
        longint unsigned v;
        num = longint'(s) * (CELL - f) + longint'(e) * f;
        v = (num * 255) / (longint'(CELL) << ENTRY_FRAC_BITS);
        return (v > 255) ? 8'd255 : v[PIXEL_BITS-1:0];
    endfunction

    // Apply one accepted word to the grading model; return 1 when a graded word is due.
    function automatic bit apply_word(input clut3d_pkg::clut_in_t w,
                                      output clut3d_pkg::clut_out_t y);
        int unsigned        base;
        int unsigned        diag;
        clut3d_pkg::entry_t s;
        clut3d_pkg::entry_t e;
        y = '0;
        if (w.opcode == clut3d_pkg::OP_LOAD)
        begin
            if (w.entry_index < TABLE_SIZE)
            begin
                lut_model[w.entry_index]  = '{w.entry_red, w.entry_green, w.entry_blue};
                lut_loaded[w.entry_index] = 1'b1;
                if (w.entry_index == LAST_IDX)
                    lut_ready = 1'b1;
            end
            return 1'b0;
        end
        if (!lut_ready)
            return 1'b0;
        lut_addr(w, base, diag);
        s = lut_model[base];
        e = lut_model[diag];
        y.graded_red   = scale_channel(s.red,   e.red,   w.pixel_red   % CELL);
        y.graded_green = scale_channel(s.green, e.green, w.pixel_green % CELL);
        y.graded_blue  = scale_channel(s.blue,  e.blue,  w.pixel_blue  % CELL);
        return 1'b1;
    endfunction

    // Build words; fields the opcode does not use carry random bits.
    function automatic clut3d_pkg::clut_in_t load_word(input int unsigned idx,
                                                       input int unsigned r,
                                                       input int unsigned g,
                                                       input int unsigned b);
        clut3d_pkg::clut_in_t w;
        w.opcode      = clut3d_pkg::OP_LOAD;
        w.pixel_red   = PIXEL_BITS'($urandom);
        w.pixel_green = PIXEL_BITS'($urandom);
        w.pixel_blue  = PIXEL_BITS'($urandom);
        w.entry_index = INDEX_BITS'(idx);
        w.entry_red   = ENTRY_BITS'(r);
        w.entry_green = ENTRY_BITS'(g);
        w.entry_blue  = ENTRY_BITS'(b);
        return w;
    endfunction

    function automatic clut3d_pkg::clut_in_t pixel_word(input int unsigned r,
                                                        input int unsigned g,
                                                        input int unsigned b);
        clut3d_pkg::clut_in_t w;
        w.opcode      = clut3d_pkg::OP_GRADE;
        w.pixel_red   = PIXEL_BITS'(r);
        w.pixel_green = PIXEL_BITS'(g);
        w.pixel_blue  = PIXEL_BITS'(b);
        w.entry_index = INDEX_BITS'($urandom);
        w.entry_red   = ENTRY_BITS'($urandom);
        w.entry_green = ENTRY_BITS'($urandom);
        w.entry_blue  = ENTRY_BITS'($urandom);
        return w;
    endfunction

    // Pixel channel: mostly uniform, otherwise a cell edge or the clamped top range.
    function automatic int unsigned rand_code();
        int unsigned edges [8] = '{0, 7, 8, 239, 240, 247, 248, 255};
        if ($urandom_range(0, 9) < 3)
            return edges[$urandom_range(0, 7)];
        return $urandom_range(0, 255);
    endfunction

    // Entry channel: mostly within 0..1.0, sometimes exactly 0 or 1.0, sometimes above.
    function automatic int unsigned rand_level();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom_range(0, 1) * 4096;
        if (pick == 1)
            return $urandom_range(4097, 8191);
        return $urandom_range(0, 4096);
    endfunction

    function automatic clut3d_pkg::clut_in_t rand_load(input int unsigned idx);
        return load_word(idx, rand_level(), rand_level(), rand_level());
    endfunction

    function automatic clut3d_pkg::clut_in_t rand_pixel();
        return pixel_word(rand_code(), rand_code(), rand_code());
    endfunction

    // Offer one word, hold it until taken, predict it, then idle for a random gap, which may be none.
    task automatic send_word(input clut3d_pkg::clut_in_t w, input bit typed,
                             input bit n_want, input clut3d_pkg::clut_out_t want);
        clut3d_pkg::clut_out_t y;
        bit                    due;
        int                    gap;
        int                    pick;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        due = apply_word(w, y);
        if (typed)
        begin
            due = n_want;
            y   = want;
        end
        if (due)
            graded_q.push_back(y);
        if (w.opcode == clut3d_pkg::OP_LOAD)
            n_loads++;
        else
            n_pixels++;
        // Mostly no gap or a short one, a few long ones, and now and then a burst with none.
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if ($urandom_range(0, 99) < 4)
        begin
            burst_left = $urandom_range(20, 80);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 98)
                gap = $urandom_range(9, 20);
            else if (pick >= 90)
                gap = $urandom_range(4, 8);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Check every graded word against the oldest pending expectation.
    always @(posedge clk)
    begin
        clut3d_pkg::clut_out_t due_word;
        if (rst_n && result_valid === 1'b1)
        begin
            if (graded_q.size() == 0)
            begin
                flag_mismatch("graded word with nothing pending");
            end
            else
            begin
                due_word = graded_q.pop_front();
                n_checked++;
                if (result.graded_red !== due_word.graded_red)
                    flag_mismatch($sformatf("graded_red %0d, want %0d",
                                            result.graded_red, due_word.graded_red));
                if (result.graded_green !== due_word.graded_green)
                    flag_mismatch($sformatf("graded_green %0d, want %0d",
                                            result.graded_green, due_word.graded_green));
                if (result.graded_blue !== due_word.graded_blue)
                    flag_mismatch($sformatf("graded_blue %0d, want %0d",
                                            result.graded_blue, due_word.graded_blue));
            end
        end
    end

    // Stop a hung run; the bound covers every word with the longest gap, many times over.
    initial
    begin
        #40_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        clut3d_pkg::clut_in_t w;
        clut3d_pkg::clut_in_t px;
        bit                   have_px;
        int unsigned          base;
        int unsigned          diag;
        int                   pick;
        logic [95:0]          noise;

        // Directed table. Pixels before ready give nothing; the corner cells pin the
        // extremes; reloads after ready show up at once; entries above 1.0 saturate.
        plan.push_back('{pixel_word(0, 0, 0), 1'b1, 1'b0, '0});
        plan.push_back('{pixel_word(255, 255, 255), 1'b1, 1'b0, '0});
        plan.push_back('{load_word(0, 0, 0, 0), 1'b0, 1'b0, '0});
        plan.push_back('{load_word(DIAG_STEP, 0, 0, 0), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(0, 0, 0), 1'b1, 1'b0, '0});
        plan.push_back('{load_word(TOP_BASE, 4096, 4096, 4096), 1'b0, 1'b0, '0});
        plan.push_back('{load_word(LAST_IDX, 4096, 4096, 4096), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(0, 0, 0), 1'b1, 1'b1, '0});
        plan.push_back('{pixel_word(7, 7, 7), 1'b1, 1'b1, '0});
        plan.push_back('{pixel_word(255, 255, 255), 1'b1, 1'b1, '1});
        plan.push_back('{pixel_word(248, 248, 248), 1'b1, 1'b1, '1});
        plan.push_back('{load_word(0, 4096, 4096, 4096), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(0, 0, 0), 1'b1, 1'b1, '1});
        plan.push_back('{pixel_word(4, 2, 6), 1'b0, 1'b0, '0});
        plan.push_back('{load_word(TOP_BASE, 8191, 0, 2048), 1'b0, 1'b0, '0});
        plan.push_back('{load_word(LAST_IDX, 8191, 0, 4095), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(255, 255, 255), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(240, 247, 251), 1'b0, 1'b0, '0});
        plan.push_back('{load_word(DIAG_STEP, 8191, 8191, 8191), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(3, 5, 1), 1'b0, 1'b0, '0});
        plan.push_back('{pixel_word(7, 0, 4), 1'b0, 1'b0, '0});

        // Hold reset low, then release it on a rising edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i].w, plan[i].typed, plan[i].n_want, plan[i].want);

        // Random mix: a pixel is held back until both of its entries hold data,
        // loading the missing ones first, so grading runs right behind its loads.
        have_px = 1'b0;
        px      = '0;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if (!have_px)
                begin
                    px      = rand_pixel();
                    have_px = 1'b1;
                end
                lut_addr(px, base, diag);
                if (!lut_loaded[base])
                begin
                    w = rand_load(base);
                end
                else if (!lut_loaded[diag])
                begin
                    w = rand_load(diag);
                end
                else
                begin
                    w       = px;
                    have_px = 1'b0;
                end
            end
            else if (pick < 85)
            begin
                w = rand_load($urandom_range(0, LAST_IDX));
            end
            else if (pick < 95)
            begin
                // Reload an entry that some pixel would read.
                w = rand_pixel();
                lut_addr(w, base, diag);
                w = rand_load(($urandom_range(0, 1) == 0) ? base : diag);
            end
            else
            begin
                noise = {$urandom, $urandom, $urandom};
                w = noise[$bits(clut3d_pkg::clut_in_t)-1:0];
                if (w.opcode == clut3d_pkg::OP_GRADE)
                begin
                    lut_addr(w, base, diag);
                    if (!(lut_loaded[base] && lut_loaded[diag]))
                        w.opcode = clut3d_pkg::OP_LOAD;
                end
            end
            send_word(w, 1'b0, 1'b0, '0);
        end
        start <= 1'b0;

        // Drain the pipeline, then keep watching for stray words.
        for (int n = 0; n < 1000 && graded_q.size() != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (graded_q.size() != 0)
            flag_mismatch($sformatf("%0d graded words never arrived", graded_q.size()));

        $display("tb: %0d table loads and %0d pixels sent, %0d graded words checked",
                 n_loads, n_pixels, n_checked);
        $display("tb: %0d mismatches", err_count);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/clut3d_pkg.sv
hdl/clut3d_front.sv
hdl/clut3d_queue.sv
hdl/clut3d_back.sv
hdl/color_lut_3d_diagonal_interp_core.sv
hdl/clut3d_checker.sv
sim/tb.sv
